@@ hdl/txp_pkg.sv @@
// shared types, constants and codes for the text palette to rgb555 parser
package txp_pkg;

  // number of palette lines expected in a file
  localparam int unsigned ColorCount = 16;

  // entry counter width: holds the color count and at least the 4-bit index
  localparam int unsigned EntryCntW =
    ($clog2(ColorCount + 1) > 4) ? $clog2(ColorCount + 1) : 4;

  // character codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharJ     = 8'h4A;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharS     = 8'h53;

  // last header byte before the color count
  localparam logic [3:0] HeaderLast = 4'd15;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_BAD_COUNT  = 2'd2
  } status_e;

  // registered input transaction
  typedef struct packed {
    logic       valid;
    logic [7:0] in_byte;
    logic       first_byte;
  } item_t;

  // result of one input transaction
  typedef struct packed {
    logic        valid;
    logic [14:0] color_word;
    logic [3:0]  color_index;
    status_e     status;
    logic        final_item;
  } result_t;

endpackage

@@ hdl/txp_ifs.sv @@
// valid/ready channel interfaces for palette bytes and color words
interface txp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_byte;

  modport source (output valid, output in_byte, output first_byte, input ready);
  modport sink (input valid, input in_byte, input first_byte, output ready);
endinterface

interface txp_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] color_word;
  logic [3:0]  color_index;
  logic [1:0]  status;
  logic        final_item;

  modport source (output valid, output color_word, output color_index,
                  output status, output final_item, input ready);
  modport sink (input valid, input color_word, input color_index,
                input status, input final_item, output ready);
endinterface

@@ hdl/txp_parse.sv @@
// byte parser state machine: header check, count, color components
module txp_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  txp_pkg::item_t   item_i,
  input  logic             advance_i,
  output txp_pkg::result_t result_o
);
  import txp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CNT_FIRST,
    PH_CNT_REST,
    PH_SKIP,
    PH_R_FIRST,
    PH_R_REST,
    PH_G_FIRST,
    PH_G_REST,
    PH_B_FIRST,
    PH_B_REST
  } phase_e;

  phase_e               phase_q, phase_d, phase_cur;
  logic [3:0]           hpos_q, hpos_d, hpos_cur;
  logic [31:0]          count_q, count_d;
  logic [7:0]           comp_q, comp_d;
  logic [4:0]           red_q, red_d;
  logic [4:0]           green_q, green_d;
  logic [EntryCntW-1:0] entry_q, entry_d;

  logic                 fire;
  logic [7:0]           b;
  logic [7:0]           digit_next;
  logic [31:0]          count_next;
  logic                 header_bad;
  logic                 entry_last;

  assign fire = item_i.valid & advance_i;
  assign b    = item_i.in_byte;

  // a first byte restarts at header byte zero
  assign phase_cur = item_i.first_byte ? PH_HEADER : phase_q;
  assign hpos_cur  = item_i.first_byte ? 4'd0 : hpos_q;

  // decimal accumulate, both wrapping
  assign digit_next = {comp_q[4:0], 3'b000} + {comp_q[6:0], 1'b0} + b - CharZero;
  assign count_next = {count_q[28:0], 3'b000} + {count_q[30:0], 1'b0}
                    + {24'd0, b} - {24'd0, CharZero};

  assign header_bad = ((hpos_cur == 4'd0) && (b != CharJ)) ||
                      ((hpos_cur == 4'd1) && (b != CharA)) ||
                      ((hpos_cur == 4'd2) && (b != CharS));

  assign entry_last = ({1'b0, entry_q} + 1'b1) >= (EntryCntW + 1)'(ColorCount);

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    hpos_d   = hpos_q;
    count_d  = count_q;
    comp_d   = comp_q;
    red_d    = red_q;
    green_d  = green_q;
    entry_d  = entry_q;
    result_o = '{valid: 1'b0, color_word: 15'd0, color_index: 4'd0,
                 status: STATUS_OK, final_item: 1'b0};
    if (item_i.first_byte) begin
      phase_d = PH_HEADER;
      hpos_d  = 4'd0;
      count_d = 32'd0;
      comp_d  = 8'd0;
      red_d   = 5'd0;
      green_d = 5'd0;
      entry_d = '0;
    end
    unique case (phase_cur)
      PH_HEADER: begin
        if (header_bad) begin
          phase_d = PH_IDLE;
          result_o.valid      = 1'b1;
          result_o.status     = STATUS_BAD_HEADER;
          result_o.final_item = 1'b1;
        end else if (hpos_cur >= HeaderLast) begin
          hpos_d  = 4'd0;
          phase_d = PH_CNT_FIRST;
        end else begin
          hpos_d = hpos_cur + 4'd1;
        end
      end
      PH_CNT_FIRST: begin
        count_d = {24'd0, b} - {24'd0, CharZero};
        phase_d = PH_CNT_REST;
      end
      PH_CNT_REST: begin
        if (b == CharCr) begin
          if (count_q != 32'(ColorCount)) begin
            phase_d = PH_IDLE;
            result_o.valid      = 1'b1;
            result_o.status     = STATUS_BAD_COUNT;
            result_o.final_item = 1'b1;
          end else begin
            entry_d = '0;
            phase_d = PH_SKIP;
          end
        end else begin
          count_d = count_next;
        end
      end
      PH_SKIP: phase_d = PH_R_FIRST;
      PH_R_FIRST: begin
        comp_d  = b - CharZero;
        phase_d = PH_R_REST;
      end
      PH_G_FIRST: begin
        comp_d  = b - CharZero;
        phase_d = PH_G_REST;
      end
      PH_B_FIRST: begin
        comp_d  = b - CharZero;
        phase_d = PH_B_REST;
      end
      PH_R_REST: begin
        if (b == CharSpace) begin
          red_d   = comp_q[7:3];
          phase_d = PH_G_FIRST;
        end else begin
          comp_d = digit_next;
        end
      end
      PH_G_REST: begin
        if (b == CharSpace) begin
          green_d = comp_q[7:3];
          phase_d = PH_B_FIRST;
        end else begin
          comp_d = digit_next;
        end
      end
      PH_B_REST: begin
        if (b == CharCr) begin
          result_o.valid       = 1'b1;
          result_o.color_word  = {comp_q[7:3], green_q, red_q};
          result_o.color_index = entry_q[3:0];
          result_o.status      = STATUS_OK;
          result_o.final_item  = entry_last;
          if (entry_last) begin
            phase_d = PH_IDLE;
          end else begin
            entry_d = entry_q + 1'b1;
            phase_d = PH_SKIP;
          end
        end else begin
          comp_d = digit_next;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    result_o.valid = result_o.valid & fire;
  end

  // parser state, updated once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hpos_q  <= 4'd0;
      count_q <= 32'd0;
      comp_q  <= 8'd0;
      red_q   <= 5'd0;
      green_q <= 5'd0;
      entry_q <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      hpos_q  <= hpos_d;
      count_q <= count_d;
      comp_q  <= comp_d;
      red_q   <= red_d;
      green_q <= green_d;
      entry_q <= entry_d;
    end
  end

endmodule

@@ hdl/txp_out_reg.sv @@
// result register driving the color word channel
module txp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  txp_pkg::result_t result_i,
  output logic             advance_o,
  txp_out_if.source        out_o
);
  import txp_pkg::*;

  logic        valid_q;
  logic [14:0] word_q;
  logic [3:0]  index_q;
  status_e     status_q;
  logic        final_q;

  // register may load when empty or being drained
  assign advance_o = ~valid_q | out_o.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= result_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      word_q   <= result_i.color_word;
      index_q  <= result_i.color_index;
      status_q <= result_i.status;
      final_q  <= result_i.final_item;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.color_word  = word_q;
  assign out_o.color_index = index_q;
  assign out_o.status      = status_q;
  assign out_o.final_item  = final_q;

endmodule

@@ hdl/text_palette_to_rgb555.sv @@
// text palette to rgb555: input register, byte parser, result register
// a byte transaction passes through the input register and the
// combinational parser into the result register; throughput: one byte per
// cycle, set by the parser state update per byte; stalls only when the
// result register is full and not being taken; reset clears both valid
// flags and returns the parser to idle, waiting for a byte flagged as first
module text_palette_to_rgb555 (
  input  logic       clk_i,
  input  logic       rst_ni,
  txp_in_if.sink     in_i,
  txp_out_if.source  out_o
);
  import txp_pkg::*;

  logic    s1_valid_q;
  logic    [7:0] s1_byte_q;
  logic    s1_first_q;
  logic    advance;
  item_t   item;
  result_t result;

  assign in_i.ready = ~s1_valid_q | advance;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q  <= in_i.in_byte;
      s1_first_q <= in_i.first_byte;
    end
  end

  assign item = '{valid: s1_valid_q, in_byte: s1_byte_q, first_byte: s1_first_q};

  txp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .advance_i (advance),
    .result_o  (result)
  );

  txp_out_reg u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .advance_o (advance),
    .out_o     (out_o)
  );

  // error results carry a zero word and the final flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != STATUS_OK)) |->
      (out_o.color_word == 15'd0 && out_o.final_item))
    else $error("error result with nonzero word or without final flag");

  // a new result only follows a transaction held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(s1_valid_q))
    else $error("result without a pending transaction");

  // an empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty result register");

  // a final color carries the last palette index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == STATUS_OK && out_o.final_item) |->
      (out_o.color_index == 4'(ColorCount - 1)))
    else $error("final color with wrong index");

endmodule

@@ verif/tb_top.sv @@
// testbench for the text palette to rgb555 parser: palette file stimulus and scoreboard
`timescale 1ns / 1ps

module tb_top;
  import txp_pkg::*;

  localparam int ClkPeriod  = 4;
  localparam int CycleLimit = 200000;

  // parser phases of the predictor
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CNT_FIRST,
    PH_CNT_REST,
    PH_SKIP,
    PH_R_FIRST,
    PH_R_REST,
    PH_G_FIRST,
    PH_G_REST,
    PH_B_FIRST,
    PH_B_REST
  } parse_phase_e;

  // one expected color word or error result
  typedef struct packed {
    logic [14:0] word;
    logic [3:0]  index;
    status_e     status;
    logic        final_item;
  } color_exp_t;

  // kinds of generated palette files
  typedef enum int {
    FILE_GOOD,
    FILE_BAD_HEADER,
    FILE_BAD_COUNT,
    FILE_CUT
  } file_kind_e;

  // palette parser predictor and color word checker
  class palette_scoreboard;
    parse_phase_e               phase;
    logic [3:0]                 hdr_pos;
    logic [31:0]                count_acc;
    logic [7:0]                 comp_acc;
    logic [4:0]                 red_hi;
    logic [4:0]                 green_hi;
    logic [EntryCntW-1:0]       entry_cnt;
    color_exp_t                 expected_colors[$];
    int                         colors_predicted;
    int                         mismatch_count;

    function new();
      phase            = PH_IDLE;
      colors_predicted = 0;
      mismatch_count   = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      hdr_pos   = '0;
      count_acc = '0;
      comp_acc  = '0;
      red_hi    = '0;
      green_hi  = '0;
      entry_cnt = '0;
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction

    // advance the parser by one accepted byte and queue any result
    function void note_byte(logic [7:0] b, logic first);
      color_exp_t e;
      bit         emit;
      emit         = 1'b0;
      e.word       = '0;
      e.index      = '0;
      e.status     = STATUS_OK;
      e.final_item = 1'b0;
      if (first) begin
        phase = PH_HEADER;
        clear_parse();
      end
      case (phase)
        PH_HEADER: begin
          if ((hdr_pos == 4'd0 && b != CharJ) || (hdr_pos == 4'd1 && b != CharA) ||
              (hdr_pos == 4'd2 && b != CharS)) begin
            phase        = PH_IDLE;
            emit         = 1'b1;
            e.status     = STATUS_BAD_HEADER;
            e.final_item = 1'b1;
          end else if (hdr_pos >= HeaderLast) begin
            hdr_pos = '0;
            phase   = PH_CNT_FIRST;
          end else begin
            hdr_pos = hdr_pos + 4'd1;
          end
        end
        PH_CNT_FIRST: begin
          count_acc = {24'd0, b} - {24'd0, CharZero};
          phase     = PH_CNT_REST;
        end
        PH_CNT_REST: begin
          if (b == CharCr) begin
            if (count_acc != 32'(ColorCount)) begin
              phase        = PH_IDLE;
              emit         = 1'b1;
              e.status     = STATUS_BAD_COUNT;
              e.final_item = 1'b1;
            end else begin
              entry_cnt = '0;
              phase     = PH_SKIP;
            end
          end else begin
            count_acc = count_acc * 32'd10 + {24'd0, b} - {24'd0, CharZero};
          end
        end
        PH_SKIP: phase = PH_R_FIRST;
        PH_R_FIRST, PH_G_FIRST, PH_B_FIRST: begin
          comp_acc = b - CharZero;
          if (phase == PH_R_FIRST) phase = PH_R_REST;
          else if (phase == PH_G_FIRST) phase = PH_G_REST;
          else phase = PH_B_REST;
        end
        PH_R_REST: begin
          if (b == CharSpace) begin
            red_hi = comp_acc[7:3];
            phase  = PH_G_FIRST;
          end else begin
            comp_acc = comp_acc * 8'd10 + b - CharZero;
          end
        end
        PH_G_REST: begin
          if (b == CharSpace) begin
            green_hi = comp_acc[7:3];
            phase    = PH_B_FIRST;
          end else begin
            comp_acc = comp_acc * 8'd10 + b - CharZero;
          end
        end
        PH_B_REST: begin
          if (b == CharCr) begin
            emit         = 1'b1;
            e.word       = {comp_acc[7:3], green_hi, red_hi};
            e.index      = entry_cnt[3:0];
            e.final_item = (int'(entry_cnt) + 1 >= int'(ColorCount));
            if (e.final_item) begin
              phase = PH_IDLE;
            end else begin
              entry_cnt = entry_cnt + 1'b1;
              phase     = PH_SKIP;
            end
          end else begin
            comp_acc = comp_acc * 8'd10 + b - CharZero;
          end
        end
        default: phase = PH_IDLE;
      endcase
      if (emit) begin
        expected_colors.push_back(e);
        colors_predicted++;
      end
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      mismatch_count++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_color(logic [14:0] word, logic [3:0] index, logic [1:0] status, logic fin);
      color_exp_t e;
      if (expected_colors.size() == 0) begin
        report($sformatf("unexpected result word %h index %0d status %0d final %b",
                         word, index, status, fin));
        return;
      end
      e = expected_colors.pop_front();
      if (word !== e.word)
        report($sformatf("color word %h, expected %h", word, e.word));
      if (index !== e.index)
        report($sformatf("color index %0d, expected %0d", index, e.index));
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (fin !== e.final_item)
        report($sformatf("final flag %b, expected %b", fin, e.final_item));
    endtask

    task flush_leftovers();
      while (expected_colors.size() != 0) begin
        void'(expected_colors.pop_front());
        report("expected result never arrived");
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm = 1'b0;
  int   cycle_count = 0;
  int   bytes_sent = 0;

  logic [7:0]        file_bytes[$];
  palette_scoreboard sb;

  txp_in_if  in_if ();
  txp_out_if out_if ();

  text_palette_to_rgb555 DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // cycle count, stall-free window and run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    calm        <= (cycle_count >= 400) && (cycle_count < 700);
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: random back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_color(out_if.color_word, out_if.color_index, out_if.status,
                     out_if.final_item);
  end

  // drive one byte transaction: starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (!calm && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= b;
    in_if.first_byte <= first;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, first);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // hold the byte stream until every predicted result has come out
  task automatic wait_for_colors();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_digit();
    return CharZero + 8'($urandom_range(9));
  endfunction

  // one color component: first byte always taken, then mostly digits, then its stop byte
  task automatic push_component(input logic [7:0] stop);
    logic [7:0] b;
    int         extra;
    extra = $urandom_range(3);
    if ($urandom_range(99) < 15) file_bytes.push_back(8'($urandom_range(255)));
    else file_bytes.push_back(rand_digit());
    repeat (extra) begin
      if ($urandom_range(99) < 5) begin
        b = 8'($urandom_range(255));
        if (b == stop) b = CharZero;
      end else begin
        b = rand_digit();
      end
      file_bytes.push_back(b);
    end
    file_bytes.push_back(stop);
  endtask

  // byte after a cr, normally lf
  task automatic push_line_end();
    if ($urandom_range(99) < 10) file_bytes.push_back(8'($urandom_range(255)));
    else file_bytes.push_back(8'h0A);
  endtask

  task automatic push_header();
    file_bytes.push_back(CharJ);
    file_bytes.push_back(CharA);
    file_bytes.push_back(CharS);
    repeat (13) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  // build one palette file into the byte queue
  task automatic build_file(input file_kind_e kind);
    int         pos;
    int         v;
    logic [7:0] b;
    file_bytes.delete();
    push_header();
    case (kind)
      FILE_BAD_HEADER: begin
        pos = $urandom_range(2);
        b   = 8'($urandom_range(255));
        if (b == file_bytes[pos]) b = ~b;
        file_bytes[pos] = b;
        while (file_bytes.size() > pos + 1 + $urandom_range(2)) void'(file_bytes.pop_back());
      end
      FILE_BAD_COUNT: begin
        case ($urandom_range(3))
          0: begin
            v = $urandom_range(99);
            if (v == 16) v = 17;
            push_text($sformatf("%0d", v));
          end
          1: repeat (11) file_bytes.push_back(rand_digit());
          2: ; // the lone cr is taken as the first count byte
          default: begin
            file_bytes.push_back(rand_digit());
            b = 8'($urandom_range(255));
            if (b == CharCr) b = CharSpace;
            file_bytes.push_back(b);
            file_bytes.push_back(rand_digit());
          end
        endcase
        file_bytes.push_back(CharCr);
      end
      default: begin
        case ($urandom_range(9))
          0: push_text("016");
          1: push_text("4294967312"); // wraps to sixteen
          default: push_text("16");
        endcase
        file_bytes.push_back(CharCr);
        push_line_end();
        repeat (ColorCount) begin
          push_component(CharSpace);
          push_component(CharSpace);
          push_component(CharCr);
          push_line_end();
        end
        if (kind == FILE_CUT) begin
          pos = $urandom_range(file_bytes.size() - 1, 1);
          while (file_bytes.size() > pos) void'(file_bytes.pop_back());
        end
      end
    endcase
  endtask

  // stimulus
  initial begin
    int         r;
    int         files;
    file_kind_e kind;
    sb               = new();
    in_if.valid      = 1'b0;
    in_if.in_byte    = '0;
    in_if.first_byte = 1'b0;
    rst_ni           = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle bytes are ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // bad header at each of the three signature bytes
    send_byte(8'hFF, 1'b1);
    send_byte(CharJ, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(CharJ, 1'b1);
    send_byte(CharA, 1'b0);
    send_byte(8'hFF, 1'b0);
    // restart in the middle of a header, then drop a good header by restarting
    send_byte(CharJ, 1'b1);
    send_byte(CharA, 1'b0);
    send_byte(CharJ, 1'b1);
    send_byte(CharA, 1'b0);
    send_byte(CharS, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(CharCr, 1'b0);
    wait_for_colors();

    // random palette files, mostly well formed
    files = 0;
    while (bytes_sent < 500 || sb.colors_predicted < 48) begin
      r = $urandom_range(99);
      if (r < 55) kind = FILE_GOOD;
      else if (r < 70) kind = FILE_BAD_COUNT;
      else if (r < 80) kind = FILE_BAD_HEADER;
      else kind = FILE_CUT;
      build_file(kind);
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
      // stray bytes between files
      if ($urandom_range(99) < 20)
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0);
      files++;
      if (files == 3) wait_for_colors();
    end

    wait_for_colors();
    repeat (8) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
